FILE: rtl/irpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared widths, register map, reset values, result kinds and the transaction
// payloads of the infrared pulse-distance decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Timer and duration width.
    localparam int unsigned TIME_W = 24;
    localparam logic [TIME_W-1:0] TIME_MASK = {TIME_W{1'b1}};

    // Divider step counter width.
    localparam int unsigned CNT_W = $clog2(TIME_W);

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_SCALE     = 2'd0;
    localparam logic [1:0] REG_BIT0_MIN  = 2'd1;
    localparam logic [1:0] REG_BIT_SPLIT = 2'd2;
    localparam logic [1:0] REG_BIT_MAX   = 2'd3;

    // Register reset values.
    localparam logic [7:0]  SCALE_RST     = 8'd9;
    localparam logic [15:0] BIT0_MIN_RST  = 16'd562;
    localparam logic [15:0] BIT_SPLIT_RST = 16'd1678;
    localparam logic [15:0] BIT_MAX_RST   = 16'd3375;

    // Result kinds.
    localparam logic [1:0] KIND_MARK  = 2'd0;
    localparam logic [1:0] KIND_SPACE = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              last_edge;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] value;
        logic              bit_error;
    } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/ir_pulse_distance_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance decoder
// Decodes NEC-style infrared frames from captured down-counter edge stamps:
// header mark and space durations, then LSB-first data bytes with an error
// flag. Durations are divided by the scale register in a bit-serial divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid / in_ready    irpd_pkg::in_item_t
//  out       output     out_valid / out_ready  irpd_pkg::out_item_t
//  cfg       input      APB psel/penable       4 registers on a 32-bit bus
//
//  An edge that needs no duration is taken in the idle state alone. An edge that
//  closes a header duration or a bit period is loaded, then runs 24 restoring
//  divider steps (one quotient bit each) and a final step that decodes and loads the result.
//  The output register holds one result; a finished item waits in its final
//  step only while that register is still full and out_ready is low.
//  Reset is asynchronous and active low; there is no clearing pass.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Edge stamp channel
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire irpd_pkg::in_item_t  in_data,
    // Result channel
    output logic                     out_valid,
    input  wire logic                out_ready,
    output irpd_pkg::out_item_t      out_data,
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef enum logic [1:0] {
        PH_EDGE0,
        PH_MARK,
        PH_SPACE,
        PH_BITS
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    // Configuration registers
    logic [7:0]  scale_reg;
    logic [15:0] bit0_min_reg;
    logic [15:0] bit_split_reg;
    logic [15:0] bit_max_reg;

    // Frame state
    phase_t                      phase_reg;
    logic                        first_burst_reg;
    logic [irpd_pkg::TIME_W-1:0] prev_edge_reg;
    logic [irpd_pkg::TIME_W-1:0] period_start_reg;
    logic                        edge_parity_reg;
    logic [7:0]                  shift_byte_reg;
    logic [2:0]                  bit_count_reg;
    logic                        error_seen_reg;
    logic                        byte_done_reg;

    // Sequencer and divider
    state_t                      state_reg;
    phase_t                      job_reg;
    logic                        last_reg;
    logic [irpd_pkg::TIME_W-1:0] div_reg;
    logic [irpd_pkg::TIME_W-1:0] div_next;
    logic [7:0]                  rem_reg;
    logic [7:0]                  rem_next;
    logic [irpd_pkg::CNT_W-1:0]  cnt_reg;

    // Output register
    logic                        out_valid_reg;
    irpd_pkg::out_item_t         out_data_reg;

    // Combinational helpers
    logic                        cfg_wr;
    logic                        accept;
    logic                        need_div;
    logic                        done_go;
    logic                        clear_frame;
    logic [7:0]                  eff_scale;
    logic [8:0]                  rem_shift;
    logic                        quot_bit;
    logic [irpd_pkg::TIME_W-1:0] diff_src;
    logic [irpd_pkg::TIME_W-1:0] diff;
    logic [irpd_pkg::TIME_W-1:0] first_time;
    logic                        is_zero;
    logic                        is_one;
    logic                        is_gap;
    logic [7:0]                  byte_next;
    logic                        err_next;

    // Handshake and port outputs.
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            irpd_pkg::REG_SCALE:     prdata = {24'd0, scale_reg};
            irpd_pkg::REG_BIT0_MIN:  prdata = {16'd0, bit0_min_reg};
            irpd_pkg::REG_BIT_SPLIT: prdata = {16'd0, bit_split_reg};
            irpd_pkg::REG_BIT_MAX:   prdata = {16'd0, bit_max_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // A zero scale divides as one.
    assign eff_scale = (scale_reg == 8'd0) ? 8'd1 : scale_reg;

    // One restoring divider step: the dividend shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    assign rem_shift = {rem_reg, div_reg[irpd_pkg::TIME_W-1]};
    assign quot_bit  = (rem_shift >= {1'b0, eff_scale});
    assign rem_next  = quot_bit ? 8'(rem_shift - {1'b0, eff_scale}) : rem_shift[7:0];
    assign div_next  = {div_reg[irpd_pkg::TIME_W-2:0], quot_bit};

    // Timer difference; a wrapped counter saturates to the full range.
    assign diff_src   = (phase_reg == PH_BITS) ? period_start_reg : prev_edge_reg;
    assign diff       = (diff_src >= in_data.edge_time) ? (diff_src - in_data.edge_time)
                                                        : irpd_pkg::TIME_MASK;
    assign first_time = (first_burst_reg && in_data.edge_time == '0) ? irpd_pkg::TIME_MASK
                                                                     : in_data.edge_time;

    // Header edges and the closing edge of a bit period need a duration.
    assign need_div = (phase_reg == PH_MARK) || (phase_reg == PH_SPACE)
                   || (phase_reg == PH_BITS && edge_parity_reg);

    // Bit period classification on the finished quotient.
    assign is_zero = (irpd_pkg::TIME_W'(bit0_min_reg) < div_reg)
                  && (div_reg < irpd_pkg::TIME_W'(bit_split_reg));
    assign is_one  = (irpd_pkg::TIME_W'(bit_split_reg) <= div_reg)
                  && (div_reg < irpd_pkg::TIME_W'(bit_max_reg));
    assign is_gap  = (bit_count_reg == 3'd0) && byte_done_reg
                  && (div_reg > irpd_pkg::TIME_W'(bit_max_reg));
    assign byte_next = is_zero ? {1'b0, shift_byte_reg[7:1]}
                     : is_one  ? {1'b1, shift_byte_reg[7:1]}
                     : shift_byte_reg;
    assign err_next  = error_seen_reg || !(is_zero || is_one);

    // The final step may proceed once the output register has room.
    assign done_go     = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign clear_frame = (accept && !need_div && in_data.last_edge) || (done_go && last_reg);

    // Sequencer, frame state, divider and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg        <= irpd_pkg::SCALE_RST;
            bit0_min_reg     <= irpd_pkg::BIT0_MIN_RST;
            bit_split_reg    <= irpd_pkg::BIT_SPLIT_RST;
            bit_max_reg      <= irpd_pkg::BIT_MAX_RST;
            phase_reg        <= PH_EDGE0;
            first_burst_reg  <= 1'b1;
            prev_edge_reg    <= '0;
            period_start_reg <= '0;
            edge_parity_reg  <= 1'b0;
            shift_byte_reg   <= 8'd0;
            bit_count_reg    <= 3'd0;
            error_seen_reg   <= 1'b0;
            byte_done_reg    <= 1'b0;
            state_reg        <= S_IDLE;
            job_reg          <= PH_EDGE0;
            last_reg         <= 1'b0;
            div_reg          <= '0;
            rem_reg          <= 8'd0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            // Configuration writes
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    irpd_pkg::REG_SCALE:     scale_reg     <= pwdata[7:0];
                    irpd_pkg::REG_BIT0_MIN:  bit0_min_reg  <= pwdata[15:0];
                    irpd_pkg::REG_BIT_SPLIT: bit_split_reg <= pwdata[15:0];
                    irpd_pkg::REG_BIT_MAX:   bit_max_reg   <= pwdata[15:0];
                    default: ;
                endcase
            end

            // Output transaction completes
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= in_data.last_edge;
                        job_reg  <= phase_reg;
                        div_reg  <= diff;
                        rem_reg  <= 8'd0;
                        cnt_reg  <= irpd_pkg::CNT_W'(irpd_pkg::TIME_W - 1);
                        unique case (phase_reg)
                            PH_EDGE0:
                            begin
                                first_burst_reg <= 1'b0;
                                prev_edge_reg   <= first_time;
                                phase_reg       <= PH_MARK;
                            end
                            PH_MARK:
                            begin
                                prev_edge_reg <= in_data.edge_time;
                                state_reg     <= S_DIV;
                            end
                            PH_SPACE:
                            begin
                                prev_edge_reg    <= in_data.edge_time;
                                period_start_reg <= in_data.edge_time;
                                edge_parity_reg  <= 1'b0;
                                state_reg        <= S_DIV;
                            end
                            PH_BITS:
                            begin
                                prev_edge_reg   <= in_data.edge_time;
                                edge_parity_reg <= !edge_parity_reg;
                                if (edge_parity_reg)
                                begin
                                    period_start_reg <= in_data.edge_time;
                                    state_reg        <= S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_DIV:
                begin
                    div_reg <= div_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (done_go)
                    begin
                        state_reg <= S_IDLE;
                        unique case (job_reg)
                            PH_MARK, PH_SPACE:
                            begin
                                out_valid_reg          <= 1'b1;
                                out_data_reg.kind      <= (job_reg == PH_MARK)
                                                          ? irpd_pkg::KIND_MARK
                                                          : irpd_pkg::KIND_SPACE;
                                out_data_reg.value     <= div_reg;
                                out_data_reg.bit_error <= 1'b0;
                                phase_reg              <= (job_reg == PH_MARK)
                                                          ? PH_SPACE : PH_BITS;
                            end
                            PH_BITS:
                            begin
                                if (is_gap)
                                begin
                                    // Frame gap: this edge opens the next header.
                                    byte_done_reg   <= 1'b0;
                                    shift_byte_reg  <= 8'd0;
                                    error_seen_reg  <= 1'b0;
                                    edge_parity_reg <= 1'b0;
                                    phase_reg       <= PH_MARK;
                                end
                                else if (bit_count_reg == 3'd7)
                                begin
                                    out_valid_reg          <= 1'b1;
                                    out_data_reg.kind      <= irpd_pkg::KIND_BYTE;
                                    out_data_reg.value     <= irpd_pkg::TIME_W'(byte_next);
                                    out_data_reg.bit_error <= err_next;
                                    shift_byte_reg         <= 8'd0;
                                    bit_count_reg          <= 3'd0;
                                    error_seen_reg         <= 1'b0;
                                    byte_done_reg          <= 1'b1;
                                end
                                else
                                begin
                                    shift_byte_reg <= byte_next;
                                    error_seen_reg <= err_next;
                                    bit_count_reg  <= bit_count_reg + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // The last edge of a burst drops any partial byte.
            if (clear_frame)
            begin
                phase_reg        <= PH_EDGE0;
                first_burst_reg  <= 1'b1;
                prev_edge_reg    <= '0;
                period_start_reg <= '0;
                edge_parity_reg  <= 1'b0;
                shift_byte_reg   <= 8'd0;
                bit_count_reg    <= 3'd0;
                error_seen_reg   <= 1'b0;
                byte_done_reg    <= 1'b0;
            end
        end
    end

    // Partial byte progress only exists while data bits are being decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bit_count_reg != 3'd0) |-> (phase_reg == PH_BITS))
    else $error("bit count set outside the data phase");

    // A pending error flag only exists while data bits are being decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        error_seen_reg |-> (phase_reg == PH_BITS))
    else $error("error flag set outside the data phase");

    // The zero-stamp substitution is armed only before the first header edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        first_burst_reg |-> (phase_reg == PH_EDGE0))
    else $error("first burst flag set past header edge zero");

    // Header durations never carry an error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.kind != irpd_pkg::KIND_BYTE)
        |-> !out_data_reg.bit_error)
    else $error("header duration flagged with a bit error");

endmodule
`default_nettype wire
